// ===== design/szl_pkg.sv =====
// ----------------------------------------------------------------------------
// szl_pkg: shared types for the sample zone lookup
// Item and result payloads, stored zone layout, action codes, sequencer
// states and the scoring weight.
// ----------------------------------------------------------------------------
package szl_pkg;

  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned SCORE_W     = 14;
  localparam int unsigned ROOT_WEIGHT = 100;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_FIND  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] velocity;
    logic [NOTE_W-1:0] lo_note;
    logic [NOTE_W-1:0] hi_note;
    logic [NOTE_W-1:0] lo_vel;
    logic [NOTE_W-1:0] hi_vel;
    logic [NOTE_W-1:0] root_note;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] zone_index;
    logic [6:0] zone_total;
    logic       table_full;
  } out_item_t;

  typedef struct packed {
    logic [NOTE_W-1:0] lo_note;
    logic [NOTE_W-1:0] hi_note;
    logic [NOTE_W-1:0] lo_vel;
    logic [NOTE_W-1:0] hi_vel;
    logic [NOTE_W-1:0] root_note;
  } zone_t;

  typedef struct packed {
    logic               hit;
    logic [SCORE_W-1:0] score;
  } score_t;

endpackage

// ===== design/szl_ram.sv =====
// ----------------------------------------------------------------------------
// szl_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module szl_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/szl_score.sv =====
// ----------------------------------------------------------------------------
// szl_score: zone match and score unit
// Tests one stored zone against the played note and velocity and gives its
// score: 1 plus velocity distance inside the note range, else 100 times the
// distance to the root note.
// ----------------------------------------------------------------------------
module szl_score (
  input  logic [szl_pkg::NOTE_W-1:0] note_i,
  input  logic [szl_pkg::NOTE_W-1:0] velocity_i,
  input  szl_pkg::zone_t             zone_i,
  output szl_pkg::score_t            score_o
);

  logic                        note_in;
  logic                        vel_in;
  logic [szl_pkg::NOTE_W-1:0]  vel_dist;
  logic [szl_pkg::NOTE_W-1:0]  root_dist;
  logic [szl_pkg::SCORE_W-1:0] near_score;
  logic [szl_pkg::SCORE_W-1:0] far_score;

  always_comb begin
    note_in = (note_i >= zone_i.lo_note) && (note_i <= zone_i.hi_note);
    vel_in  = (velocity_i >= zone_i.lo_vel) && (velocity_i <= zone_i.hi_vel);

    if (velocity_i < zone_i.lo_vel) begin
      vel_dist = zone_i.lo_vel - velocity_i;
    end else if (velocity_i > zone_i.hi_vel) begin
      vel_dist = velocity_i - zone_i.hi_vel;
    end else begin
      vel_dist = '0;
    end

    if (note_i >= zone_i.root_note) begin
      root_dist = note_i - zone_i.root_note;
    end else begin
      root_dist = zone_i.root_note - note_i;
    end

    near_score = szl_pkg::SCORE_W'(vel_dist) + szl_pkg::SCORE_W'(1);
    far_score  = szl_pkg::SCORE_W'(root_dist) * szl_pkg::SCORE_W'(szl_pkg::ROOT_WEIGHT);

    score_o.hit   = note_in && vel_in;
    score_o.score = note_in ? near_score : far_score;
  end

endmodule

// ===== design/sample_zone_lookup.sv =====
// ----------------------------------------------------------------------------
// sample_zone_lookup: key zone table with best-match search
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one item at a
// time: add a zone, clear the table, or find a zone for a note and velocity.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
// result per item from an output register.
// Add, clear, an unused action or a find on an empty table go straight to
// the finish state, which loads the output register once it is free; the
// next item is taken back in idle. A find over stored zones scans them, one
// zone per cycle from the zone memory through a single score unit, ending at
// the first zone that holds note and velocity; in_ready_o is low throughout.
// Reset empties the table at once; the zone memory itself is not cleared.
// When the receiver stalls, the result is held and the block takes one more
// item; its result waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module sample_zone_lookup #(
  parameter int unsigned MAX_ZONES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  szl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output szl_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int unsigned CW = $clog2(MAX_ZONES + 1);

  szl_pkg::state_e state_q, state_d;

  logic [CW-1:0]               fill_q;
  logic [CW-1:0]               rd_idx_q;
  logic                        chk_valid_q;
  logic [AW-1:0]               chk_idx_q;
  logic                        have_q;
  logic [szl_pkg::SCORE_W-1:0] best_q;
  logic [AW-1:0]               best_idx_q;
  logic                        res_found_q;
  logic [AW-1:0]               res_idx_q;
  logic                        res_full_q;
  logic                        out_valid_q;
  szl_pkg::out_item_t          out_q;
  szl_pkg::in_item_t           item_q;

  logic            in_xfer;
  logic            is_add;
  logic            is_clear;
  logic            is_find;
  logic            tbl_full;
  logic            ram_we;
  logic            scan_issue;
  logic            scan_hit;
  logic            scan_end;
  logic            out_load;
  szl_pkg::zone_t  new_zone;
  szl_pkg::zone_t  rd_zone;
  szl_pkg::score_t sc;
  logic [AW+5:0]   idx_ext;
  logic [CW+6:0]   fill_ext;

  // Action decode
  always_comb begin
    is_add   = 1'b0;
    is_clear = 1'b0;
    is_find  = 1'b0;
    unique case (szl_pkg::action_e'(in_data_i.action))
      szl_pkg::ACT_ADD:   is_add   = 1'b1;
      szl_pkg::ACT_CLEAR: is_clear = 1'b1;
      szl_pkg::ACT_FIND:  is_find  = 1'b1;
      default: ;
    endcase
  end

  assign tbl_full = (fill_q == CW'(MAX_ZONES));
  assign in_xfer  = in_valid_i && in_ready_o;

  assign new_zone.lo_note   = in_data_i.lo_note;
  assign new_zone.hi_note   = in_data_i.hi_note;
  assign new_zone.lo_vel    = in_data_i.lo_vel;
  assign new_zone.hi_vel    = in_data_i.hi_vel;
  assign new_zone.root_note = in_data_i.root_note;

  szl_ram #(
    .WIDTH ($bits(szl_pkg::zone_t)),
    .DEPTH (MAX_ZONES)
  ) u_zone_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (new_zone),
    .re_i    (scan_issue),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rd_zone)
  );

  szl_score u_score (
    .note_i     (item_q.note),
    .velocity_i (item_q.velocity),
    .zone_i     (rd_zone),
    .score_o    (sc)
  );

  assign scan_hit = chk_valid_q && sc.hit;
  assign scan_end = !chk_valid_q && (rd_idx_q >= fill_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      szl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = (is_find && (fill_q != '0)) ? szl_pkg::ST_SCAN : szl_pkg::ST_FINISH;
        end
      end
      szl_pkg::ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_d = szl_pkg::ST_FINISH;
        end
      end
      szl_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = szl_pkg::ST_IDLE;
        end
      end
      default: state_d = szl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    scan_issue = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      szl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_we     = in_valid_i && is_add && !tbl_full;
      end
      szl_pkg::ST_SCAN: begin
        scan_issue = (rd_idx_q < fill_q);
      end
      szl_pkg::ST_FINISH: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= szl_pkg::ST_IDLE;
      fill_q      <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_valid_q <= scan_issue && !scan_hit;
      if (ram_we) begin
        fill_q <= fill_q + CW'(1);
      end else if (in_xfer && is_clear) begin
        fill_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign idx_ext  = {6'b0, res_idx_q};
  assign fill_ext = {7'b0, fill_q};

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q      <= in_data_i;
      rd_idx_q    <= '0;
      have_q      <= 1'b0;
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
      res_full_q  <= is_add && tbl_full;
    end
    if (scan_issue) begin
      rd_idx_q  <= rd_idx_q + CW'(1);
      chk_idx_q <= rd_idx_q[AW-1:0];
    end
    if (state_q == szl_pkg::ST_SCAN) begin
      if (scan_hit) begin
        res_found_q <= 1'b1;
        res_idx_q   <= chk_idx_q;
      end else if (chk_valid_q) begin
        if (!have_q || (sc.score < best_q)) begin
          have_q     <= 1'b1;
          best_q     <= sc.score;
          best_idx_q <= chk_idx_q;
        end
      end else if (scan_end) begin
        res_found_q <= have_q;
        res_idx_q   <= have_q ? best_idx_q : '0;
      end
    end
    if (out_load) begin
      out_q.found      <= res_found_q;
      out_q.zone_index <= idx_ext[5:0];
      out_q.zone_total <= fill_ext[6:0];
      out_q.table_full <= res_full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_ZONES))
    else $error("zone count above table size");

  a_chk_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_valid_q |-> ({1'b0, chk_idx_q} < {1'b0, fill_q[CW-1:0]}))
    else $error("scan checks a zone beyond the table");

  a_full_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_full_q) |=> (out_data_o.zone_total == 7'(MAX_ZONES)))
    else $error("dropped add reported with table not full");

  a_found_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_found_q) |-> ({1'b0, res_idx_q} < {1'b0, fill_q[CW-1:0]}))
    else $error("found zone index outside table");

  a_scan_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_find && (fill_q != '0)) |=> !in_ready_o)
    else $error("new transfer taken during a scan");

endmodule
